/* hdl/multi_slot_value_toggler_top_defines.svh */
// Assertion macros for the value toggler
`ifndef MULTI_SLOT_VALUE_TOGGLER_TOP_DEFINES_SVH
`define MULTI_SLOT_VALUE_TOGGLER_TOP_DEFINES_SVH
// implication checked on every clock, off while in reset
`define MSVT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define MSVT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hdl/msvt_pkg.sv */
// Package for the value toggler: sizes, opcodes, slot record, states
package msvt_pkg;
    localparam int SLOTS = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = 6;
    localparam logic [10:0] ID_MASK = 11'h7FF;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_STOPALL = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WALK,
        S_SEND,
        S_STAT
    } t_state;

    typedef struct packed {
        logic        active;
        logic [10:0] id;
        logic [15:0] first;
        logic [15:0] second;
        logic [15:0] leave;
        logic [15:0] current;
        logic [31:0] period;
        logic [31:0] duration;
        logic [47:0] stop_time;
        logic [47:0] next_toggle;
    } t_slot;

    // one-slot decision from the shared compare unit
    typedef struct packed {
        logic        match;
        logic        expire;
        logic        due;
        logic [15:0] toggled;
    } t_eval;
endpackage

/* hdl/multi_slot_value_toggler_top.sv */
// Top level of the value toggler: slot table, sequencer and stream ports
//  channel | dir | tdata fields (low bit first)            | tuser
//  s_axis  | in  | opcode,now_ms,chan_id,first_value,       | -
//          |     | second_value,leave_value,period,duration,|
//          |     | send_exit,run_enable                     |
//  m_axis  | out | out_id,out_value,status,stopped_count    | is_send; tlast=last
// Start and stop scan the slots one per cycle, then pass through the send and status states.
// Stop all and tick walk the slots in order and close the walk, then pass through the status state.
// Every slot is judged in turn by the single compare unit.
// Sends are issued from the walk or send state; an output stall holds them there.
// Reset is synchronous active low and frees every slot at once.
// Output stalls hold the walk or the send; input is taken only when idle.
`include "multi_slot_value_toggler_top_defines.svh"
module multi_slot_value_toggler_top import msvt_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode,now_ms,chan_id,first_value,second_value,leave_value,period,
    // duration,send_exit,run_enable, zero pad
    input  logic [175:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_id,out_value,status,stopped_count, zero pad
    output logic [39:0]  m_axis_tdata,
    // is_send
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);
    t_slot r_slot [SLOTS];
    t_state r_state, n_state;
    logic [1:0]   r_op;
    logic [47:0]  r_now;
    logic [10:0]  r_id;
    logic [15:0]  r_v1, r_v2, r_vx;
    logic [31:0]  r_per, r_dur;
    logic         r_sx, r_run;
    logic [SLOT_W:0] r_idx, n_idx;
    logic         r_hit, n_hit;
    logic [SLOT_W-1:0] r_sel, n_sel;
    logic         r_free_ok, n_free_ok;
    logic [SLOT_W-1:0] r_free, n_free;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]   n_act;   // 0 none,1 clear,2 rearm
    logic         r_ov, r_ou, r_ol, r_ost;
    logic [10:0]  r_oid;
    logic [15:0]  r_oval;
    logic [CNT_W-1:0] r_ocnt;

    localparam logic [1:0] A_NONE = 2'd0, A_CLEAR = 2'd1, A_REARM = 2'd2;

    t_slot cur;
    t_eval ev;
    logic [SLOT_W-1:0] widx;
    logic in_acc, out_free;

    assign widx = r_idx[SLOT_W-1:0];
    assign cur = r_slot[widx];
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ov || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    msvt_eval u_eval (.i_slot(cur), .i_now(r_now), .i_id(r_id), .o_eval(ev));

    // start/stop resolution in S_SEND
    logic start_ok, stop_ok;
    logic [SLOT_W-1:0] tgt;
    assign start_ok = (r_per != 32'd0) && (r_hit || r_free_ok);
    assign stop_ok = r_hit;
    assign tgt = r_hit ? r_sel : r_free;
    t_slot tslot;
    assign tslot = r_slot[tgt];

    logic send_ss, ld_send, r_err;
    assign send_ss = (r_state == S_SEND) &&
                     ((t_op'(r_op) == OP_START) ? start_ok : stop_ok);
    assign ld_send = send_ss && out_free;

    logic emit, emit_stat;
    logic [10:0] e_id;
    logic [15:0] e_val;

    always_comb begin
        n_state = r_state; n_idx = r_idx; n_hit = r_hit; n_sel = r_sel;
        n_free_ok = r_free_ok; n_free = r_free; n_cnt = r_cnt;
        n_act = A_NONE;
        emit = 1'b0; emit_stat = 1'b0;
        e_id = cur.id; e_val = cur.leave;
        unique case (r_state)
            S_IDLE: if (in_acc) begin
                n_idx = '0; n_hit = 1'b0; n_free_ok = 1'b0; n_cnt = '0;
                n_state = (s_axis_tdata[1:0] == OP_START || s_axis_tdata[1:0] == OP_STOP)
                          ? S_SCAN : S_WALK;
            end
            S_SCAN: begin
                if (ev.match && !r_hit) begin n_hit = 1'b1; n_sel = widx; end
                if (!cur.active && !r_free_ok) begin n_free_ok = 1'b1; n_free = widx; end
                if (r_idx == (SLOT_W+1)'(SLOTS - 1) || SLOTS == 1) n_state = S_SEND;
                n_idx = r_idx + 1'b1;
            end
            S_WALK: begin
                if (r_idx == (SLOT_W+1)'(SLOTS)) n_state = S_STAT;
                else if (!cur.active || (t_op'(r_op) == OP_TICK && !r_run)) begin
                    n_idx = r_idx + 1'b1;
                end else if (t_op'(r_op) == OP_STOPALL) begin
                    if (!r_sx || out_free) begin
                        emit = r_sx; n_act = A_CLEAR;
                        n_cnt = r_cnt + 1'b1; n_idx = r_idx + 1'b1;
                    end
                end else if (ev.expire) begin
                    if (out_free) begin emit = 1'b1; n_act = A_CLEAR; n_idx = r_idx + 1'b1; end
                end else if (ev.due) begin
                    if (out_free) begin
                        emit = 1'b1; e_val = ev.toggled; n_act = A_REARM;
                        n_idx = r_idx + 1'b1;
                    end
                end else n_idx = r_idx + 1'b1;
            end
            S_SEND: begin
                // a rejected item goes straight to status; a send waits for the output
                if (!send_ss || out_free) n_state = S_STAT;
            end
            S_STAT: if (out_free) begin
                emit_stat = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ov <= 1'b0; r_idx <= '0; r_err <= 1'b0;
            for (int k = 0; k < SLOTS; k++) r_slot[k] <= '0;
        end else begin
            r_state <= n_state; r_idx <= n_idx;
            if (ld_send || emit || emit_stat) r_ov <= 1'b1;
            else if (m_axis_tready) r_ov <= 1'b0;
            if (r_state == S_IDLE) r_err <= 1'b0;
            else if (r_state == S_SEND && !send_ss) r_err <= 1'b1;
            if (ld_send) begin
                r_ou <= 1'b1; r_ol <= 1'b0; r_ost <= 1'b0;
                r_ocnt <= '0;
                if (t_op'(r_op) == OP_START) begin
                    r_oid <= r_id; r_oval <= r_v1;
                    r_slot[tgt] <= '{active: 1'b1, id: r_id, first: r_v1,
                        second: r_v2, leave: r_vx, current: r_v1, period: r_per,
                        duration: r_dur,
                        stop_time: (r_dur != 32'd0) ? r_now + 48'(r_dur) : 48'd0,
                        next_toggle: r_now + 48'(r_per)};
                end else begin
                    r_oid <= tslot.id; r_oval <= tslot.leave;
                    r_slot[tgt] <= '0;
                end
            end
            if (emit) begin
                r_ou <= 1'b1; r_ol <= 1'b0; r_ost <= 1'b0;
                r_ocnt <= '0; r_oid <= e_id; r_oval <= e_val;
            end
            if (emit_stat) begin
                r_ou <= 1'b0; r_ol <= 1'b1; r_ost <= r_err;
                r_oid <= '0; r_oval <= '0;
                r_ocnt <= (t_op'(r_op) == OP_STOPALL) ? r_cnt : '0;
            end
            if (n_act == A_CLEAR) r_slot[widx] <= '0;
            else if (n_act == A_REARM) begin
                r_slot[widx].current <= e_val;
                r_slot[widx].next_toggle <= r_now + 48'(cur.period);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= n_hit; r_sel <= n_sel; r_free_ok <= n_free_ok; r_free <= n_free;
        r_cnt <= n_cnt;
        if (in_acc) begin
            r_op  <= s_axis_tdata[1:0];
            r_now <= s_axis_tdata[49:2];
            r_id  <= s_axis_tdata[60:50];
            r_v1  <= s_axis_tdata[76:61];
            r_v2  <= s_axis_tdata[92:77];
            r_vx  <= s_axis_tdata[108:93];
            r_per <= s_axis_tdata[140:109];
            r_dur <= s_axis_tdata[172:141];
            r_sx  <= s_axis_tdata[173];
            r_run <= s_axis_tdata[174];
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser = r_ou;
    assign m_axis_tlast = r_ol;
    assign m_axis_tdata = {5'd0, r_ocnt, r_ost, r_oval, r_oid};

    `MSVT_ASSERT_IMP(a_ready_idle, s_axis_tready, r_state == S_IDLE)
    `MSVT_ASSERT_IMP(a_last_status, r_ov && r_ol, !r_ou)
    `MSVT_ASSERT_NXT(a_stat_done, emit_stat, r_state == S_IDLE && r_ov && r_ol)
endmodule

/* hdl/msvt_eval.sv */
// Shared compare unit: judges one slot against the current item
module msvt_eval import msvt_pkg::*; (
    input  t_slot       i_slot,
    input  logic [47:0] i_now,
    input  logic [10:0] i_id,
    output t_eval       o_eval
);
    always_comb begin
        o_eval.match   = i_slot.active && (i_slot.id == i_id);
        o_eval.expire  = (i_slot.duration != 32'd0) && (i_slot.stop_time != 48'd0)
                         && (i_now >= i_slot.stop_time);
        o_eval.due     = i_now >= i_slot.next_toggle;
        o_eval.toggled = (i_slot.current == i_slot.first) ? i_slot.second : i_slot.first;
    end
endmodule

/* sim/tb_multi_slot_value_toggler_top.sv */
// Self-checking stream testbench for the multi-slot value toggler
`timescale 1ns / 100ps
module tb_multi_slot_value_toggler_top;
    import msvt_pkg::*;

    localparam int NSLOT = 8;
    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic        is_send;
        logic [10:0] out_id;
        logic [15:0] out_value;
        logic        status;
        logic [5:0]  stopped_count;
        logic        last;
    } t_toggle_res;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [175:0] s_axis_tdata;   // opcode,now_ms,chan_id,first,second,leave,period,duration,
                                  // send_exit,run_enable, zero pad
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [39:0]  m_axis_tdata;   // out_id,out_value,status,stopped_count, zero pad
    logic         m_axis_tuser;   // is_send
    logic         m_axis_tlast;

    t_toggle_res  pending_res[$];
    int           fail_cnt;
    int           idle_cycles;
    logic [47:0]  now_ms;

    // shadow slot table
    logic         sh_active[NSLOT];
    logic [10:0]  sh_id[NSLOT];
    logic [15:0]  sh_first[NSLOT];
    logic [15:0]  sh_second[NSLOT];
    logic [15:0]  sh_leave[NSLOT];
    logic [15:0]  sh_cur[NSLOT];
    logic [31:0]  sh_period[NSLOT];
    logic [31:0]  sh_dur[NSLOT];
    logic [47:0]  sh_stop[NSLOT];
    logic [47:0]  sh_next[NSLOT];

    multi_slot_value_toggler_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 3) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic clear_slot(int k);
        sh_active[k] = 1'b0; sh_id[k] = '0; sh_first[k] = '0; sh_second[k] = '0;
        sh_leave[k] = '0; sh_cur[k] = '0; sh_period[k] = '0; sh_dur[k] = '0;
        sh_stop[k] = '0; sh_next[k] = '0;
    endtask

    task automatic push_send(int k, logic [15:0] v);
        t_toggle_res r;
        sh_cur[k] = v;
        r = '0;
        r.is_send = 1'b1; r.out_id = sh_id[k]; r.out_value = v;
        pending_res.push_back(r);
    endtask

    function automatic int find_chan(logic [10:0] id);
        for (int k = 0; k < NSLOT; k++)
            if (sh_active[k] && sh_id[k] == id) return k;
        return -1;
    endfunction

    // expected sends and status for one accepted command
    task automatic predict_toggles(t_op op, logic [47:0] t, logic [10:0] id,
                                   logic [15:0] v1, logic [15:0] v2, logic [15:0] vx,
                                   logic [31:0] per, logic [31:0] dur, logic sx, logic run);
        t_toggle_res st;
        int k;
        st = '0;
        st.last = 1'b1;
        case (op)
            OP_START: begin
                k = -1;
                if (per != 0) begin
                    k = find_chan(id);
                    if (k < 0)
                        for (int j = 0; j < NSLOT; j++)
                            if (!sh_active[j] && k < 0) k = j;
                end
                if (k < 0) begin
                    st.status = 1'b1;
                end else begin
                    sh_id[k] = id; sh_first[k] = v1; sh_second[k] = v2; sh_leave[k] = vx;
                    sh_period[k] = per; sh_dur[k] = dur; sh_active[k] = 1'b1;
                    sh_stop[k] = (dur != 0) ? t + 48'(dur) : '0;
                    push_send(k, v1);
                    sh_next[k] = t + 48'(per);
                end
            end
            OP_STOP: begin
                k = find_chan(id);
                if (k < 0) st.status = 1'b1;
                else begin
                    push_send(k, sh_leave[k]);
                    clear_slot(k);
                end
            end
            OP_STOPALL: begin
                for (int j = 0; j < NSLOT; j++)
                    if (sh_active[j]) begin
                        if (sx) push_send(j, sh_leave[j]);
                        clear_slot(j);
                        st.stopped_count++;
                    end
            end
            default: begin
                if (run)
                    for (int j = 0; j < NSLOT; j++) begin
                        if (!sh_active[j]) continue;
                        if (sh_dur[j] != 0 && sh_stop[j] != 0 && t >= sh_stop[j]) begin
                            push_send(j, sh_leave[j]);
                            clear_slot(j);
                            continue;
                        end
                        if (t < sh_next[j]) continue;
                        push_send(j, (sh_cur[j] == sh_first[j]) ? sh_second[j] : sh_first[j]);
                        sh_next[j] = t + 48'(sh_period[j]);
                    end
            end
        endcase
        pending_res.push_back(st);
    endtask

    // tvalid stays high after acceptance when the next transaction follows at once
    task automatic send_cmd(t_op op, logic [47:0] t, logic [10:0] id,
                            logic [15:0] v1, logic [15:0] v2, logic [15:0] vx,
                            logic [31:0] per, logic [31:0] dur, logic sx, logic run);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, run, sx, dur, per, vx, v2, v1, id, t, op};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_toggles(op, t, id, v1, v2, vx, per, dur, sx, run);
    endtask

    task automatic advance_ms(int unsigned lo, int unsigned hi);
        now_ms = now_ms + 48'($urandom_range(lo, hi));
    endtask

    task automatic test_start_stop();
        send_cmd(OP_START, now_ms, 11'h000, 16'h0000, 16'hFFFF, 16'h1234, 32'd10, 32'd0,
                 1'b0, 1'b0);
        send_cmd(OP_START, now_ms, 11'h7FF, 16'hFFFF, 16'h0000, 16'hAAAA,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_cmd(OP_START, now_ms, 11'h055, 16'h1, 16'h2, 16'h3, 32'd0, 32'd5, 1'b0, 1'b0);
        send_cmd(OP_START, now_ms, 11'h000, 16'h5555, 16'hAAAA, 16'h0F0F, 32'd7, 32'd30,
                 1'b0, 1'b0);
        send_cmd(OP_STOP, now_ms, 11'h7FF, '0, '0, '0, '0, '0, 1'b0, 1'b0);
        send_cmd(OP_STOP, now_ms, 11'h3AB, '0, '0, '0, '0, '0, 1'b0, 1'b0);
    endtask

    task automatic test_tick_toggle();
        // equal levels exercise the toggle choice when current matches start
        send_cmd(OP_START, now_ms, 11'h011, 16'h4242, 16'h4242, 16'h9, 32'd3, 32'd0,
                 1'b0, 1'b0);
        send_cmd(OP_TICK, now_ms + 48'd100, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0);
        for (int i = 0; i < 6; i++) begin
            advance_ms(2, 8);
            send_cmd(OP_TICK, now_ms, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
        end
    endtask

    task automatic test_full_and_stopall();
        for (int i = 0; i < NSLOT + 1; i++)
            send_cmd(OP_START, now_ms, 11'(i + 100), 16'(i), 16'(i + 50), 16'(i + 900),
                     32'd4, 32'(i * 3), 1'b0, 1'b0);
        send_cmd(OP_STOPALL, now_ms, '0, '0, '0, '0, '0, '0, 1'b1, 1'b0);
        send_cmd(OP_START, now_ms, 11'h1, 16'h1, 16'h2, 16'h3, 32'd1, 32'd1, 1'b0, 1'b0);
        send_cmd(OP_START, now_ms, 11'h2, 16'h1, 16'h2, 16'h3, 32'd1, 32'd0, 1'b0, 1'b0);
        send_cmd(OP_STOPALL, now_ms, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
        send_cmd(OP_STOPALL, now_ms, '0, '0, '0, '0, '0, '0, 1'b1, 1'b0);
    endtask

    task automatic test_time_wrap();
        // stop time wrapping to zero must never expire
        now_ms = 48'hFFFF_FFFF_FFF0;
        send_cmd(OP_START, now_ms, 11'h321, 16'h10, 16'h20, 16'h30, 32'd8, 32'h10,
                 1'b0, 1'b0);
        send_cmd(OP_START, now_ms, 11'h322, 16'h10, 16'h20, 16'h30, 32'h20, 32'h11,
                 1'b0, 1'b0);
        send_cmd(OP_TICK, 48'hFFFF_FFFF_FFFF, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
        send_cmd(OP_STOPALL, now_ms, '0, '0, '0, '0, '0, '0, 1'b1, 1'b0);
        now_ms = '0;
    endtask

    task automatic test_random_traffic();
        int unsigned sel;
        logic [10:0] id;
        for (int i = 0; i < 125; i++) begin
            sel = $urandom_range(0, 99);
            id = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(0, 11));
            if (sel < 35)
                send_cmd(OP_START, now_ms, id, 16'($urandom), 16'($urandom), 16'($urandom),
                         ($urandom_range(0, 15) == 0) ? 32'd0 :
                         ($urandom_range(0, 15) == 0) ? 32'($urandom) :
                         32'($urandom_range(1, 20)),
                         ($urandom_range(0, 3) == 0) ? 32'd0 :
                         ($urandom_range(0, 15) == 0) ? 32'($urandom) :
                         32'($urandom_range(1, 80)),
                         1'($urandom), 1'($urandom));
            else if (sel < 50)
                send_cmd(OP_STOP, now_ms, id, 16'($urandom), 16'($urandom), 16'($urandom),
                         32'($urandom), 32'($urandom), 1'($urandom), 1'($urandom));
            else if (sel < 54)
                send_cmd(OP_STOPALL, now_ms, id, 16'($urandom), 16'($urandom), 16'($urandom),
                         32'($urandom), 32'($urandom), 1'($urandom), 1'($urandom));
            else begin
                advance_ms(0, 12);
                send_cmd(OP_TICK, now_ms, id, 16'($urandom), 16'($urandom), 16'($urandom),
                         32'($urandom), 32'($urandom), 1'($urandom),
                         ($urandom_range(0, 7) != 0));
            end
        end
        // high time bits
        now_ms = {16'($urandom), 32'($urandom)};
        send_cmd(OP_TICK, now_ms, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
        send_cmd(OP_START, now_ms, 11'h400, 16'h8000, 16'h7FFF, 16'hC3C3, 32'h8000_0000,
                 32'h8000_0001, 1'b1, 1'b1);
        send_cmd(OP_STOPALL, now_ms, '0, '0, '0, '0, '0, '0, 1'b1, 1'b0);
    endtask

    // result side: random stalls and the checker
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = pick_gap();
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready)) @(posedge i_clk);
            begin
                t_toggle_res got, exp_r;
                got.is_send = m_axis_tuser;
                got.out_id = m_axis_tdata[10:0];
                got.out_value = m_axis_tdata[26:11];
                got.status = m_axis_tdata[27];
                got.stopped_count = m_axis_tdata[33:28];
                got.last = m_axis_tlast;
                if (pending_res.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    fail_cnt++;
                end else begin
                    exp_r = pending_res.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        fail_cnt = 0;
        idle_cycles = 0;
        now_ms = '0;
        for (int k = 0; k < NSLOT; k++) clear_slot(k);
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_start_stop();
        test_tick_toggle();
        test_full_and_stopall();
        test_time_wrap();
        test_random_traffic();
        s_axis_tvalid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
